/* rtl/ntp_pkg.sv */
// ntp_pkg: shared types and constants for the NoC traffic probe.
// Used by every module under rtl/. No dependencies.
package ntp_pkg;

    localparam int unsigned ID_SHIFT = 48;
    localparam int unsigned SRC_W    = 16;
    localparam int unsigned CNT_W    = 32;
    localparam int unsigned WIDE_W   = 64;
    localparam int unsigned FIRST_W  = 48;

    // Input action codes as carried on the action port
    typedef enum logic [1:0] {
        KIND_TICK   = 2'd0,
        KIND_ACK    = 2'd1,
        KIND_ARRIVE = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        FAULT_NONE     = 2'd0,
        FAULT_MISMATCH = 2'd1,
        FAULT_REJECT   = 2'd2
    } fault_t;

    // Register map index (byte address is 8 * index)
    typedef enum logic [2:0] {
        REG_SOURCE_ID    = 3'd0,
        REG_DEST_ID      = 3'd1,
        REG_PAYLOAD_SIZE = 3'd2,
        REG_PKTS_SEND    = 3'd3,
        REG_PKTS_RECV    = 3'd4,
        REG_FIRST_CYCLE  = 3'd5,
        REG_GAP_CYCLES   = 3'd6,
        REG_TIME_STEP    = 3'd7
    } reg_idx_t;

    // Settings the back end needs
    typedef struct packed {
        logic [SRC_W-1:0]   source_id;
        logic [CNT_W-1:0]   pkts_send;
        logic [CNT_W-1:0]   pkts_recv;
        logic [FIRST_W-1:0] first_cycle;
        logic [CNT_W-1:0]   gap_cycles;
    } cfg_t;

    // Classified transaction passed from front to back
    typedef struct packed {
        kind_t             kind;
        logic [WIDE_W-1:0] ack_id;
        logic              ack_accepted;
        logic              ack_retryable;
        logic [WIDE_W-1:0] latency;
    } item_t;

endpackage

/* rtl/noc_traffic_probe.sv */
// noc_traffic_probe: top level; configuration registers, APB port, and
// front stage, queue and back end. Depends on ntp_pkg, ntp_front, ntp_queue, ntp_core.
//
//  channel | direction | handshake            | contents
//  --------+-----------+----------------------+------------------------------------------
//  in      | to probe  | in_valid / in_stall  | action, ack_id, ack flags, now_ns, sent_ns
//  out     | from probe| out_valid / out_stall| packet fields, error, done, counters
//  apb     | to probe  | psel/penable/pready  | 64-bit bus, registers at byte addr 8*index
//
// One transaction per clock cycle sustained while out_stall stays low. An accepted
// transaction passes through the input register, the queue and the result register
// before out_valid rises. The back end's state update (64-bit cycle add and compares)
// sets the rate. Reset is asynchronous and active low and clears all control state;
// first_cycle resets to one, other registers to zero. A stalled output holds the
// back end; the queue absorbs in-flight transactions and in_stall rises only
// once it is full.
module noc_traffic_probe #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    // input transactions
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  action,
    input  logic [63:0] ack_id,
    input  logic        ack_accepted,
    input  logic        ack_retryable,
    input  logic [63:0] now_ns,
    input  logic [63:0] sent_ns,
    // result transactions
    output logic        out_valid,
    input  logic        out_stall,
    output logic        send_valid,
    output logic [63:0] pkt_id,
    output logic [31:0] send_index,
    output logic [32:0] event_seq,
    output logic [1:0]  error_code,
    output logic        done_res,
    output logic [31:0] sent_count,
    output logic [31:0] received_count,
    output logic [31:0] retry_count,
    output logic [63:0] latency_total,
    output logic [63:0] latency_peak,
    output logic [63:0] cycle_count,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import ntp_pkg::*;

    logic [SRC_W-1:0]   source_id_reg;
    logic [SRC_W-1:0]   dest_id_reg;
    logic [SRC_W-1:0]   payload_size_reg;
    logic [CNT_W-1:0]   pkts_send_reg;
    logic [CNT_W-1:0]   pkts_recv_reg;
    logic [FIRST_W-1:0] first_cycle_reg;
    logic [CNT_W-1:0]   gap_cycles_reg;
    logic [CNT_W-1:0]   time_step_reg;

    reg_idx_t reg_sel;
    logic     cfg_write;
    cfg_t     cfg;

    logic     push;
    item_t    push_item;
    logic     q_ready;
    logic     q_valid;
    item_t    q_item;
    logic     pop;

    // APB: zero wait states, register picked by paddr[5:3]
    assign pready    = 1'b1;
    assign reg_sel   = reg_idx_t'(paddr[5:3]);
    assign cfg_write = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_id_reg    <= '0;
            dest_id_reg      <= '0;
            payload_size_reg <= '0;
            pkts_send_reg    <= '0;
            pkts_recv_reg    <= '0;
            first_cycle_reg  <= FIRST_W'(1);
            gap_cycles_reg   <= '0;
            time_step_reg    <= '0;
        end
        else if (cfg_write)
        begin
            case (reg_sel)
                REG_SOURCE_ID:    source_id_reg    <= pwdata[SRC_W-1:0];
                REG_DEST_ID:      dest_id_reg      <= pwdata[SRC_W-1:0];
                REG_PAYLOAD_SIZE: payload_size_reg <= pwdata[SRC_W-1:0];
                REG_PKTS_SEND:    pkts_send_reg    <= pwdata[CNT_W-1:0];
                REG_PKTS_RECV:    pkts_recv_reg    <= pwdata[CNT_W-1:0];
                REG_FIRST_CYCLE:  first_cycle_reg  <= pwdata[FIRST_W-1:0];
                REG_GAP_CYCLES:   gap_cycles_reg   <= pwdata[CNT_W-1:0];
                REG_TIME_STEP:    time_step_reg    <= pwdata[CNT_W-1:0];
                default:          time_step_reg    <= time_step_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_SOURCE_ID:    prdata = 64'(source_id_reg);
            REG_DEST_ID:      prdata = 64'(dest_id_reg);
            REG_PAYLOAD_SIZE: prdata = 64'(payload_size_reg);
            REG_PKTS_SEND:    prdata = 64'(pkts_send_reg);
            REG_PKTS_RECV:    prdata = 64'(pkts_recv_reg);
            REG_FIRST_CYCLE:  prdata = 64'(first_cycle_reg);
            REG_GAP_CYCLES:   prdata = 64'(gap_cycles_reg);
            REG_TIME_STEP:    prdata = 64'(time_step_reg);
            default:          prdata = '0;
        endcase
    end

    // destination, payload size and time step reach no logic; read-back only
    always_comb
    begin
        cfg.source_id   = source_id_reg;
        cfg.pkts_send   = pkts_send_reg;
        cfg.pkts_recv   = pkts_recv_reg;
        cfg.first_cycle = first_cycle_reg;
        cfg.gap_cycles  = gap_cycles_reg;
    end

    ntp_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .ack_id        (ack_id),
        .ack_accepted  (ack_accepted),
        .ack_retryable (ack_retryable),
        .now_ns        (now_ns),
        .sent_ns       (sent_ns),
        .push          (push),
        .push_item     (push_item),
        .q_ready       (q_ready)
    );

    ntp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .q_ready   (q_ready),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .pop       (pop)
    );

    ntp_core u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .q_valid        (q_valid),
        .q_item         (q_item),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .send_valid     (send_valid),
        .pkt_id         (pkt_id),
        .send_index     (send_index),
        .event_seq      (event_seq),
        .error_code     (error_code),
        .done_res       (done_res),
        .sent_count     (sent_count),
        .received_count (received_count),
        .retry_count    (retry_count),
        .latency_total  (latency_total),
        .latency_peak   (latency_peak),
        .cycle_count    (cycle_count)
    );

endmodule

/* rtl/ntp_front.sv */
// ntp_front: input register stage; classifies a transaction and
// precomputes the floored arrival latency. Depends on ntp_pkg.
module ntp_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [1:0]                 action,
    input  logic [63:0]                ack_id,
    input  logic                       ack_accepted,
    input  logic                       ack_retryable,
    input  logic [63:0]                now_ns,
    input  logic [63:0]                sent_ns,
    output logic                       push,
    output ntp_pkg::item_t             push_item,
    input  logic                       q_ready
);
    import ntp_pkg::*;

    logic  front_valid_reg, front_valid_next;
    item_t item_reg;
    item_t item_new;
    logic  accept;

    assign in_stall = front_valid_reg & ~q_ready;
    assign accept   = in_valid & ~in_stall;
    assign push     = front_valid_reg & q_ready;
    assign push_item = item_reg;

    always_comb
    begin
        item_new.kind          = kind_t'(action);
        item_new.ack_id        = ack_id;
        item_new.ack_accepted  = ack_accepted;
        item_new.ack_retryable = ack_retryable;
        // latency floored at zero
        item_new.latency       = (now_ns >= sent_ns) ? (now_ns - sent_ns) : '0;
        front_valid_next       = accept | (front_valid_reg & ~q_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else
        begin
            front_valid_reg <= front_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_new;
        end
    end

endmodule

/* rtl/ntp_queue.sv */
// ntp_queue: short FIFO decoupling the front stage from the back end.
// Depends on ntp_pkg for the item type.
module ntp_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  ntp_pkg::item_t push_item,
    output logic           q_ready,
    output logic           q_valid,
    output ntp_pkg::item_t q_item,
    input  logic           pop
);
    import ntp_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W_Q = $clog2(DEPTH + 1);

    item_t              mem [DEPTH];
    logic [PTR_W-1:0]   head_reg, head_next;
    logic [PTR_W-1:0]   tail_reg, tail_next;
    logic [CNT_W_Q-1:0] count_reg, count_next;

    assign q_ready = (count_reg != CNT_W_Q'(DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_item  = mem[head_reg];

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (push)
        begin
            tail_next = (tail_reg == PTR_W'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;
        end
        if (pop)
        begin
            head_next = (head_reg == PTR_W'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[tail_reg] <= push_item;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg != CNT_W_Q'(DEPTH)))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("queue pop while empty");

endmodule

/* rtl/ntp_core.sv */
// ntp_core: back end; executes one transaction per cycle against the probe state
// while its output is not stalled, and registers the result. Depends on ntp_pkg.
module ntp_core (
    input  logic           clk,
    input  logic           rst_n,
    input  ntp_pkg::cfg_t  cfg,
    input  logic           q_valid,
    input  ntp_pkg::item_t q_item,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_stall,
    output logic           send_valid,
    output logic [63:0]    pkt_id,
    output logic [31:0]    send_index,
    output logic [32:0]    event_seq,
    output logic [1:0]     error_code,
    output logic           done_res,
    output logic [31:0]    sent_count,
    output logic [31:0]    received_count,
    output logic [31:0]    retry_count,
    output logic [63:0]    latency_total,
    output logic [63:0]    latency_peak,
    output logic [63:0]    cycle_count
);
    import ntp_pkg::*;

    logic [WIDE_W-1:0] cycles_reg, cycles_next;
    logic [CNT_W-1:0]  sent_reg, sent_next;
    logic [WIDE_W-1:0] next_send_reg, next_send_next;
    logic              in_flight_reg, in_flight_next;
    logic [WIDE_W-1:0] flight_id_reg, flight_id_next;
    logic [CNT_W-1:0]  received_reg, received_next;
    logic [CNT_W-1:0]  retries_reg, retries_next;
    logic [WIDE_W-1:0] lat_sum_reg, lat_sum_next;
    logic [WIDE_W-1:0] lat_max_reg, lat_max_next;
    logic              finished_reg, finished_next;
    fault_t            fault_reg, fault_next;

    logic              out_valid_reg, out_valid_next;
    logic              send_valid_reg, send_valid_next;
    logic [WIDE_W-1:0] pid_reg, pid_next;
    logic [CNT_W-1:0]  index_reg, index_next;
    logic [CNT_W:0]    seq_reg, seq_next;

    logic [WIDE_W-1:0] cycles_inc;
    logic [WIDE_W-1:0] new_pid;
    logic              fire;
    logic              id_match;
    logic              check_done;

    assign pop        = q_valid & (~out_valid_reg | ~out_stall);
    assign cycles_inc = cycles_reg + 1'b1;
    assign new_pid    = {cfg.source_id, {(ID_SHIFT - CNT_W){1'b0}}, sent_reg};
    assign fire       = ~finished_reg & ~in_flight_reg & (sent_reg < cfg.pkts_send)
                      & (cycles_inc >= {{(WIDE_W - FIRST_W){1'b0}}, cfg.first_cycle})
                      & (cycles_inc >= next_send_reg);
    assign id_match   = in_flight_reg & (q_item.ack_id == flight_id_reg);

    always_comb
    begin
        cycles_next     = cycles_reg;
        sent_next       = sent_reg;
        next_send_next  = next_send_reg;
        in_flight_next  = in_flight_reg;
        flight_id_next  = flight_id_reg;
        received_next   = received_reg;
        retries_next    = retries_reg;
        lat_sum_next    = lat_sum_reg;
        lat_max_next    = lat_max_reg;
        fault_next      = fault_reg;
        check_done      = 1'b0;
        send_valid_next = 1'b0;
        pid_next        = '0;
        index_next      = '0;
        seq_next        = '0;

        if (pop && fault_reg == FAULT_NONE)
        begin
            case (q_item.kind)
                KIND_TICK:
                begin
                    cycles_next = cycles_inc;
                    check_done  = 1'b1;
                    if (fire)
                    begin
                        send_valid_next = 1'b1;
                        pid_next        = new_pid;
                        index_next      = sent_reg;
                        seq_next        = {1'b0, sent_reg} + 1'b1;
                        flight_id_next  = new_pid;
                        in_flight_next  = 1'b1;
                    end
                end
                KIND_ACK:
                begin
                    if (!id_match)
                    begin
                        fault_next = FAULT_MISMATCH;
                    end
                    else
                    begin
                        in_flight_next = 1'b0;
                        if (q_item.ack_accepted)
                        begin
                            sent_next      = sent_reg + 1'b1;
                            next_send_next = cycles_reg
                                           + {{(WIDE_W - CNT_W){1'b0}}, cfg.gap_cycles}
                                           + 1'b1;
                            check_done     = 1'b1;
                        end
                        else if (q_item.ack_retryable)
                        begin
                            retries_next = retries_reg + 1'b1;
                            check_done   = 1'b1;
                        end
                        else
                        begin
                            fault_next = FAULT_REJECT;
                        end
                    end
                end
                KIND_ARRIVE:
                begin
                    lat_sum_next  = lat_sum_reg + q_item.latency;
                    lat_max_next  = (q_item.latency > lat_max_reg) ? q_item.latency
                                                                   : lat_max_reg;
                    received_next = received_reg + 1'b1;
                    check_done    = 1'b1;
                end
                default:
                begin
                    check_done = 1'b0;
                end
            endcase
        end

        finished_next = finished_reg
                      | (check_done & (sent_next == cfg.pkts_send) & ~in_flight_next
                         & (received_next == cfg.pkts_recv));
        out_valid_next = pop | (out_valid_reg & out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cycles_reg    <= '0;
            sent_reg      <= '0;
            next_send_reg <= '0;
            in_flight_reg <= 1'b0;
            flight_id_reg <= '0;
            received_reg  <= '0;
            retries_reg   <= '0;
            lat_sum_reg   <= '0;
            lat_max_reg   <= '0;
            finished_reg  <= 1'b0;
            fault_reg     <= FAULT_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cycles_reg    <= cycles_next;
            sent_reg      <= sent_next;
            next_send_reg <= next_send_next;
            in_flight_reg <= in_flight_next;
            flight_id_reg <= flight_id_next;
            received_reg  <= received_next;
            retries_reg   <= retries_next;
            lat_sum_reg   <= lat_sum_next;
            lat_max_reg   <= lat_max_next;
            finished_reg  <= finished_next;
            fault_reg     <= fault_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            send_valid_reg <= send_valid_next;
            pid_reg        <= pid_next;
            index_reg      <= index_next;
            seq_reg        <= seq_next;
        end
    end

    // state only moves on pop, so while a result waits it shows the state after it
    assign out_valid      = out_valid_reg;
    assign send_valid     = send_valid_reg;
    assign pkt_id         = pid_reg;
    assign send_index     = index_reg;
    assign event_seq      = seq_reg;
    assign error_code     = fault_reg;
    assign done_res       = finished_reg;
    assign sent_count     = sent_reg;
    assign received_count = received_reg;
    assign retry_count    = retries_reg;
    assign latency_total  = lat_sum_reg;
    assign latency_peak   = lat_max_reg;
    assign cycle_count    = cycles_reg;

    a_fault_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (fault_reg != FAULT_NONE) |=> $stable(fault_reg) && $stable(cycles_reg))
        else $error("halted probe changed state");

    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        finished_reg |=> finished_reg)
        else $error("done flag cleared");

    a_send_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && send_valid_reg) |-> (in_flight_reg && flight_id_reg == pid_reg))
        else $error("pending send result without matching packet in flight");

endmodule

/* tb/tb_noc_traffic_probe.sv */
// tb_noc_traffic_probe: self-checking bench for the NoC traffic probe. Sends a table of
// directed transactions and then random ones, predicts each result and checks APB read-back.
// Depends on ntp_pkg and the noc_traffic_probe top level.
module tb_noc_traffic_probe;
    timeunit 1ns;
    timeprecision 1ps;

    import ntp_pkg::*;

    // Random transactions per idle profile; noise transactions (action code three)
    // are on top of this.
    localparam int unsigned PHASE_TXNS   = 430;
    localparam longint      RUN_LIMIT_NS = 4_000_000;

    // Idle profiles: none, sender idle, receiver stalling, both
    localparam int SEND_IDLE [4] = '{0, 55, 0, 30};
    localparam int OUT_STALL [4] = '{0, 0, 55, 30};

    // One input transaction, as on the input ports
    typedef struct packed {
        kind_t       action;
        logic [63:0] ack_id;
        logic        accepted;
        logic        retryable;
        logic [63:0] now_ns;
        logic [63:0] sent_ns;
    } probe_txn_t;

    // One result transaction, as on the output ports
    typedef struct packed {
        logic        send_valid;
        logic [63:0] pkt_id;
        logic [31:0] send_index;
        logic [32:0] event_seq;
        logic [1:0]  error_code;
        logic        done_res;
        logic [31:0] sent_count;
        logic [31:0] received_count;
        logic [31:0] retry_count;
        logic [63:0] latency_total;
        logic [63:0] latency_peak;
        logic [63:0] cycle_count;
    } probe_status_t;

    // Directed row: live_id takes ack_id from the packet in flight when the row is sent;
    // reset_state means the result is the all-zero status straight after reset.
    typedef struct packed {
        probe_txn_t txn;
        logic       live_id;
        logic       reset_state;
    } dir_row_t;

    localparam int DIR_ROWS = 19;
    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        // ignored code with reset settings: nothing may move
        '{'{KIND_NONE,   64'h0, 1'b0, 1'b0, 64'h0, 64'h0}, 1'b0, 1'b1},
        // ticks before first_cycle (3); the unused fields at their extremes
        '{'{KIND_TICK,   '1,    1'b1, 1'b1, '1,    '1},    1'b0, 1'b0},
        '{'{KIND_TICK,   64'h0, 1'b0, 1'b0, 64'h0, 64'h0}, 1'b0, 1'b0},
        // first_cycle reached: packet 0 goes out, then nothing while it is in flight
        '{'{KIND_TICK,   64'h0, 1'b0, 1'b0, 64'h0, 64'h0}, 1'b0, 1'b0},
        '{'{KIND_TICK,   64'h0, 1'b0, 1'b0, 64'h0, 64'h0}, 1'b0, 1'b0},
        // retryable rejection, resend, then acceptance with both flags set
        '{'{KIND_ACK,    64'h0, 1'b0, 1'b1, 64'h0, 64'h0}, 1'b1, 1'b0},
        '{'{KIND_TICK,   64'h0, 1'b0, 1'b0, 64'h0, 64'h0}, 1'b0, 1'b0},
        '{'{KIND_ACK,    64'h0, 1'b1, 1'b1, 64'h0, 64'h0}, 1'b1, 1'b0},
        // gap of two idle ticks, then packet 1
        '{'{KIND_TICK,   64'h0, 1'b0, 1'b0, 64'h0, 64'h0}, 1'b0, 1'b0},
        '{'{KIND_TICK,   64'h0, 1'b0, 1'b0, 64'h0, 64'h0}, 1'b0, 1'b0},
        '{'{KIND_TICK,   64'h0, 1'b0, 1'b0, 64'h0, 64'h0}, 1'b0, 1'b0},
        '{'{KIND_ACK,    64'h0, 1'b1, 1'b0, 64'h0, 64'h0}, 1'b1, 1'b0},
        // arrivals: plain, stamp after now (floored), largest, sum wrap, equal extremes
        '{'{KIND_ARRIVE, 64'h0, 1'b0, 1'b0, 64'd100, 64'd40}, 1'b0, 1'b0},
        '{'{KIND_ARRIVE, 64'h0, 1'b0, 1'b0, 64'd5,   64'd9},  1'b0, 1'b0},
        '{'{KIND_ARRIVE, 64'h0, 1'b0, 1'b0, '1,      64'h0},  1'b0, 1'b0},
        '{'{KIND_ARRIVE, 64'h0, 1'b0, 1'b0, 64'd2,   64'h0},  1'b0, 1'b0},
        '{'{KIND_ARRIVE, 64'h0, 1'b0, 1'b0, '1,      '1},     1'b0, 1'b0},
        '{'{KIND_NONE,   '1,    1'b1, 1'b1, '1,      '1},     1'b0, 1'b0},
        '{'{KIND_TICK,   64'h0, 1'b0, 1'b0, 64'h0,  64'h0},   1'b0, 1'b0}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    kind_t       action = KIND_TICK;
    logic [63:0] ack_id = '0;
    logic        ack_accepted = 1'b0;
    logic        ack_retryable = 1'b0;
    logic [63:0] now_ns = '0;
    logic [63:0] sent_ns = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        send_valid;
    logic [63:0] pkt_id;
    logic [31:0] send_index;
    logic [32:0] event_seq;
    logic [1:0]  error_code;
    logic        done_res;
    logic [31:0] sent_count;
    logic [31:0] received_count;
    logic [31:0] retry_count;
    logic [63:0] latency_total;
    logic [63:0] latency_peak;
    logic [63:0] cycle_count;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [5:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;

    // Predicted probe state
    logic [63:0] st_cycles = '0;
    logic [31:0] st_sent = '0;
    logic [63:0] st_next_send = '0;
    logic        st_in_flight = 1'b0;
    logic [63:0] st_in_flight_id = '0;
    logic [31:0] st_received = '0;
    logic [31:0] st_retries = '0;
    logic [63:0] st_lat_sum = '0;
    logic [63:0] st_lat_max = '0;
    logic        st_finished = 1'b0;
    fault_t      st_fault = FAULT_NONE;

    // Settings as the probe should hold them; read-back values per register
    logic [15:0] cfg_source_id = '0;
    logic [31:0] cfg_pkts_send = '0;
    logic [31:0] cfg_pkts_recv = '0;
    logic [47:0] cfg_first_cycle = 48'd1;
    logic [31:0] cfg_gap = '0;
    logic [63:0] reg_shadow [8] = '{64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd1, 64'd0, 64'd0};

    probe_status_t awaited_status [$];
    int            error_count = 0;
    int            result_idx = 0;
    int            send_idle_pct = 0;
    int            stall_pct = 0;

    noc_traffic_probe u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .action         (action),
        .ack_id         (ack_id),
        .ack_accepted   (ack_accepted),
        .ack_retryable  (ack_retryable),
        .now_ns         (now_ns),
        .sent_ns        (sent_ns),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .send_valid     (send_valid),
        .pkt_id         (pkt_id),
        .send_index     (send_index),
        .event_seq      (event_seq),
        .error_code     (error_code),
        .done_res       (done_res),
        .sent_count     (sent_count),
        .received_count (received_count),
        .retry_count    (retry_count),
        .latency_total  (latency_total),
        .latency_peak   (latency_peak),
        .cycle_count    (cycle_count),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Hard stop in case the probe hangs
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("noc_traffic_probe: mismatch");
        $finish;
    end

    task automatic log_error(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic cmp_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
        if (got !== want)
            log_error($sformatf("result %0d %s: got %h, expected %h",
                                result_idx, name, got, want));
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] reg_mask(input reg_idx_t idx);
        case (idx)
            REG_SOURCE_ID, REG_DEST_ID, REG_PAYLOAD_SIZE: return 64'hFFFF;
            REG_FIRST_CYCLE:                              return 64'hFFFF_FFFF_FFFF;
            default:                                      return 64'hFFFF_FFFF;
        endcase
    endfunction

    // Done latches once every packet is sent and acknowledged and the expected
    // number of arrivals has been seen exactly.
    function automatic void refresh_done();
        if (!st_finished && st_sent == cfg_pkts_send && !st_in_flight &&
            st_received == cfg_pkts_recv)
            st_finished = 1'b1;
    endfunction

    // Advances the predicted state by one transaction and returns the status it reports.
    function automatic probe_status_t probe_next_status(input probe_txn_t t);
        probe_status_t r;
        logic [63:0]   lat;
        r = '0;
        if (st_fault == FAULT_NONE)
        begin
            case (t.action)
                KIND_TICK:
                begin
                    st_cycles = st_cycles + 64'd1;
                    if (!st_finished && !st_in_flight && st_sent < cfg_pkts_send &&
                        st_cycles >= {16'd0, cfg_first_cycle} && st_cycles >= st_next_send)
                    begin
                        r.send_valid    = 1'b1;
                        r.pkt_id        = {cfg_source_id, 16'd0, st_sent};
                        r.send_index    = st_sent;
                        r.event_seq     = {1'b0, st_sent} + 33'd1;
                        st_in_flight_id = r.pkt_id;
                        st_in_flight    = 1'b1;
                    end
                    refresh_done();
                end
                KIND_ACK:
                begin
                    if (!st_in_flight || t.ack_id != st_in_flight_id)
                    begin
                        st_fault = FAULT_MISMATCH;
                    end
                    else
                    begin
                        st_in_flight = 1'b0;
                        if (t.accepted)
                        begin
                            st_sent      = st_sent + 32'd1;
                            st_next_send = st_cycles + {32'd0, cfg_gap} + 64'd1;
                            refresh_done();
                        end
                        else if (t.retryable)
                        begin
                            st_retries = st_retries + 32'd1;
                            refresh_done();
                        end
                        else
                        begin
                            st_fault = FAULT_REJECT;
                        end
                    end
                end
                KIND_ARRIVE:
                begin
                    lat = (t.now_ns >= t.sent_ns) ? t.now_ns - t.sent_ns : 64'd0;
                    st_lat_sum = st_lat_sum + lat;
                    if (lat > st_lat_max)
                        st_lat_max = lat;
                    st_received = st_received + 32'd1;
                    refresh_done();
                end
                default: ;
            endcase
        end
        r.error_code     = st_fault;
        r.done_res       = st_finished;
        r.sent_count     = st_sent;
        r.received_count = st_received;
        r.retry_count    = st_retries;
        r.latency_total  = st_lat_sum;
        r.latency_peak   = st_lat_max;
        r.cycle_count    = st_cycles;
        return r;
    endfunction

    // Random transaction. Acks only ever refer to the packet in flight, so the block
    // keeps running; unused fields carry random bits. 'anything' drops all rules.
    function automatic probe_txn_t pick_txn(input bit arrivals_ok, input bit anything);
        probe_txn_t  t;
        int unsigned roll;
        t.action    = KIND_TICK;
        t.ack_id    = rand64();
        t.accepted  = 1'($urandom_range(1));
        t.retryable = 1'($urandom_range(1));
        t.now_ns    = rand64();
        t.sent_ns   = rand64();
        roll        = $urandom_range(99);
        if (anything)
        begin
            t.action = kind_t'(2'($urandom_range(3)));
        end
        else if (roll < 5)
        begin
            t.action = KIND_NONE;
        end
        else if (st_in_flight && roll < 45)
        begin
            t.action    = KIND_ACK;
            t.ack_id    = st_in_flight_id;
            t.retryable = t.accepted ? t.retryable : 1'b1;
        end
        else if (arrivals_ok && roll >= 75)
        begin
            t.action = KIND_ARRIVE;
            case ($urandom_range(3))
                0: ;                                       // both stamps random
                1: t.now_ns = t.sent_ns + 64'($urandom_range(1000));
                2: t.now_ns = t.sent_ns;
                default:
                begin                                      // huge latency, sum wraps
                    t.sent_ns    = 64'($urandom_range(4095));
                    t.now_ns[63] = 1'b1;
                end
            endcase
        end
        return t;
    endfunction

    // Presents one transaction, holds it until taken and records the expected status.
    task automatic issue_txn(input probe_txn_t t, input bit reset_state);
        probe_status_t want;
        in_valid      <= 1'b1;
        action        <= t.action;
        ack_id        <= t.ack_id;
        ack_accepted  <= t.accepted;
        ack_retryable <= t.retryable;
        now_ns        <= t.now_ns;
        sent_ns       <= t.sent_ns;
        do @(posedge clk); while (in_stall);
        want = probe_next_status(t);
        if (reset_state)
            awaited_status.push_back('0);
        else
            awaited_status.push_back(want);
    endtask

    // Always lets at least one edge pass, so valid never gets two updates in one step
    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (awaited_status.size() != 0);
    endtask

    task automatic maybe_pause();
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
        else if ($urandom_range(199) == 0)
        begin
            wait_drained();
        end
    endtask

    task automatic run_traffic(input int unsigned count);
        probe_txn_t  t;
        int unsigned done_txns;
        done_txns = 0;
        while (done_txns < count)
        begin
            t = pick_txn(1'b1, 1'b0);
            maybe_pause();
            issue_txn(t, 1'b0);
            if (t.action != KIND_NONE)
                done_txns++;
        end
    endtask

    task automatic apb_write(input reg_idx_t idx, input logic [63:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apb_check(input reg_idx_t idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 3'b000};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== reg_shadow[idx])
            log_error($sformatf("register %s read %h, expected %h",
                                idx.name(), prdata, reg_shadow[idx]));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Bits above the register width are junk on the bus and must be dropped
    task automatic set_reg(input reg_idx_t idx, input logic [63:0] value);
        logic [63:0] kept;
        kept = value & reg_mask(idx);
        apb_write(idx, kept | (rand64() & ~reg_mask(idx)));
        reg_shadow[idx] = kept;
        case (idx)
            REG_SOURCE_ID:   cfg_source_id   = kept[15:0];
            REG_PKTS_SEND:   cfg_pkts_send   = kept[31:0];
            REG_PKTS_RECV:   cfg_pkts_recv   = kept[31:0];
            REG_FIRST_CYCLE: cfg_first_cycle = kept[47:0];
            REG_GAP_CYCLES:  cfg_gap         = kept[31:0];
            default: ;
        endcase
        apb_check(idx);
    endtask

    function automatic logic [63:0] corner_or_random(input int p);
        return (p == 0) ? 64'd0 : (p == 1) ? '1 : rand64();
    endfunction

    // Targets stay out of reach during the random phases so done cannot latch early:
    // received_count never gets near 2^32-1, and is already past zero.
    task automatic configure_phase(input int p);
        set_reg(REG_SOURCE_ID, corner_or_random(p));
        set_reg(REG_DEST_ID, corner_or_random(p));
        set_reg(REG_PAYLOAD_SIZE, corner_or_random(p));
        set_reg(REG_TIME_STEP, corner_or_random(p));
        set_reg(REG_PKTS_SEND, (p == 0) ? 64'hFFFF_FFFF : {33'd1, 31'($urandom)});
        set_reg(REG_PKTS_RECV, (p == 2) ? 64'd0 : 64'hFFFF_FFFF);
        set_reg(REG_FIRST_CYCLE, (p == 0) ? 64'd0 : st_cycles + 64'($urandom_range(30)));
        set_reg(REG_GAP_CYCLES, (p == 0) ? 64'd0 : 64'($urandom_range(8)));
    endtask

    // Result side: check every accepted result, then pick the next stall at random
    always @(posedge clk)
    begin : result_check
        probe_status_t want;
        if (out_valid && !out_stall)
        begin
            if (awaited_status.size() == 0)
            begin
                log_error("result transaction with nothing outstanding");
            end
            else
            begin
                want = awaited_status.pop_front();
                cmp_field("send_valid", 64'(send_valid), 64'(want.send_valid));
                cmp_field("pkt_id", pkt_id, want.pkt_id);
                cmp_field("send_index", 64'(send_index), 64'(want.send_index));
                cmp_field("event_seq", 64'(event_seq), 64'(want.event_seq));
                cmp_field("error_code", 64'(error_code), 64'(want.error_code));
                cmp_field("done_res", 64'(done_res), 64'(want.done_res));
                cmp_field("sent_count", 64'(sent_count), 64'(want.sent_count));
                cmp_field("received_count", 64'(received_count),
                          64'(want.received_count));
                cmp_field("retry_count", 64'(retry_count), 64'(want.retry_count));
                cmp_field("latency_total", latency_total, want.latency_total);
                cmp_field("latency_peak", latency_peak, want.latency_peak);
                cmp_field("cycle_count", cycle_count, want.cycle_count);
                result_idx++;
            end
        end
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    initial
    begin : stimulus
        probe_txn_t t;
        bit         take_done_path;
        int         guard;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values of every register
        for (int i = 0; i < 8; i++)
            apb_check(reg_idx_t'(i));

        // Directed table. Row 0 runs on reset settings; the rest with source 0xFFFF,
        // first_cycle 3 and a gap of 2, targets out of reach.
        for (int r = 0; r < DIR_ROWS; r++)
        begin
            if (r == 1)
            begin
                wait_drained();
                repeat (2) @(posedge clk);
                set_reg(REG_SOURCE_ID, 64'hFFFF);
                set_reg(REG_DEST_ID, rand64());
                set_reg(REG_PAYLOAD_SIZE, rand64());
                set_reg(REG_TIME_STEP, rand64());
                set_reg(REG_PKTS_SEND, 64'hFFFF_FFFF);
                set_reg(REG_PKTS_RECV, 64'hFFFF_FFFF);
                set_reg(REG_FIRST_CYCLE, 64'd3);
                set_reg(REG_GAP_CYCLES, 64'd2);
            end
            t = DIRECTED[r].txn;
            if (DIRECTED[r].live_id)
                t.ack_id = st_in_flight_id;
            issue_txn(t, DIRECTED[r].reset_state);
        end

        // Random phases, one per idle profile. Settings change only once the probe
        // has delivered everything outstanding.
        for (int p = 0; p < 4; p++)
        begin
            wait_drained();
            repeat (2) @(posedge clk);
            send_idle_pct = SEND_IDLE[p];
            stall_pct     = OUT_STALL[p];
            if (p == 1)
            begin
                // Sending blocked twice over: nothing to send, start cycle unreachable
                set_reg(REG_PKTS_SEND, 64'd0);
                set_reg(REG_FIRST_CYCLE, 64'hFFFF_FFFF_FFFF);
                run_traffic(16);
                wait_drained();
                repeat (2) @(posedge clk);
            end
            configure_phase(p);
            run_traffic(PHASE_TXNS);
        end

        // Done and both error codes are sticky and reset comes only once, so a run
        // ends in one of two ways, chosen at random.
        wait_drained();
        repeat (2) @(posedge clk);
        take_done_path = 1'($urandom_range(1));
        set_reg(REG_GAP_CYCLES, 64'hFFFF_FFFF);
        if (take_done_path)
        begin
            // One more packet, four more arrivals; the maximum gap blocks any further send
            set_reg(REG_PKTS_SEND, 64'(st_sent) + 64'd1);
            set_reg(REG_PKTS_RECV, 64'(st_received) + 64'd4);
            set_reg(REG_FIRST_CYCLE, 64'd0);
            guard = 0;
            while (!st_finished && guard < 3000)
            begin
                t = pick_txn(st_received < cfg_pkts_recv, 1'b0);
                maybe_pause();
                issue_txn(t, 1'b0);
                guard++;
            end
            // Done stays set: ticks still count, arrivals overshoot the target
            run_traffic(30);
            // Nothing is in flight now, so any ack is a mismatch
            t        = pick_txn(1'b1, 1'b0);
            t.action = KIND_ACK;
            issue_txn(t, 1'b0);
        end
        else
        begin
            guard = 0;
            while (!st_in_flight && guard < 3000)
            begin
                t        = pick_txn(1'b1, 1'b0);
                t.action = KIND_TICK;
                issue_txn(t, 1'b0);
                guard++;
            end
            // Permanent rejection of the packet in flight
            t           = pick_txn(1'b1, 1'b0);
            t.action    = KIND_ACK;
            t.ack_id    = st_in_flight_id;
            t.accepted  = 1'b0;
            t.retryable = 1'b0;
            issue_txn(t, 1'b0);
        end

        // Halted: everything from here on is ignored
        for (int k = 0; k < 12; k++)
        begin
            t = pick_txn(1'b1, 1'b1);
            maybe_pause();
            issue_txn(t, 1'b0);
        end

        wait_drained();
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("noc_traffic_probe: match");
        else
            $display("noc_traffic_probe: mismatch");
        $finish;
    end

endmodule
